// File: hdl/sk_pkg.sv
// Shared types and constants for the sorted key table.
package sk_pkg;

  // Field widths of the transactions.
  localparam int KeyW    = 32;
  localparam int PayW    = 32;
  localparam int FuncW   = 2;
  localparam int PosW    = 8;
  localparam int SlotW   = 9;
  localparam int CountW  = 9;
  localparam int StatusW = 2;

  // Index field wide enough for the largest supported table (4096 entries).
  localparam int IdxMaxW = 12;

  // Number of cells folded into one group of the payload read tree.
  localparam int GrpSize = 16;

  // Operation codes.
  typedef enum logic [FuncW-1:0] {
    FN_LOOKUP = 2'd0,
    FN_INSERT = 2'd1,
    FN_DELETE = 2'd2
  } func_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    STS_OK     = 2'd0,
    STS_FULL   = 2'd1,
    STS_BADIDX = 2'd2
  } status_e;

  // Shift command seen by every cell.
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_INS,
    CMD_DEL
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e             op;
    logic [IdxMaxW-1:0]  idx;
    logic [KeyW-1:0]     key;
    logic [PayW-1:0]     payload;
  } shift_cmd_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_SEARCH,
    S_READ_GRP,
    S_READ_ALL,
    S_EXEC,
    S_FINISH
  } fsm_e;

endpackage

// File: hdl/sk_ifs.sv
// Request and result channel interfaces of the sorted key table.
interface sk_in_if import sk_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [FuncW-1:0]        func;
  logic signed [KeyW-1:0]  key;
  logic [PayW-1:0]         payload;
  logic [PosW-1:0]         position;

  modport source (output valid, func, key, payload, position, input ready);
  modport sink   (input valid, func, key, payload, position, output ready);
endinterface

interface sk_out_if import sk_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                found;
  logic [SlotW-1:0]    slot;
  logic [PayW-1:0]     data;
  logic [CountW-1:0]   entries;
  logic [StatusW-1:0]  status;

  modport source (output valid, found, slot, data, entries, status, input ready);
  modport sink   (input valid, found, slot, data, entries, status, output ready);
endinterface

// File: hdl/sk_cell.sv
// One table cell: holds a key and payload, compares, and shifts with its neighbors.
module sk_cell import sk_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic                    clk_i,
  input  shift_cmd_t              cmd_i,
  input  logic signed [KeyW-1:0]  want_i,
  input  logic [KeyW-1:0]         prev_key_i,
  input  logic [PayW-1:0]         prev_pay_i,
  input  logic [KeyW-1:0]         next_key_i,
  input  logic [PayW-1:0]         next_pay_i,
  output logic [KeyW-1:0]         key_o,
  output logic [PayW-1:0]         pay_o,
  output logic                    lt_o,
  output logic                    eq_o,
  output logic [PayW-1:0]         rd_o
);

  localparam logic [IdxMaxW-1:0] MyIdx = IdxMaxW'(IDX);

  logic [KeyW-1:0] key_q, key_d;
  logic [PayW-1:0] pay_q, pay_d;

  // Shift right on insert at or before this cell, shift left on delete.
  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    unique case (cmd_i.op)
      CMD_INS: begin
        if (MyIdx > cmd_i.idx) begin
          key_d = prev_key_i;
          pay_d = prev_pay_i;
        end else if (MyIdx == cmd_i.idx) begin
          key_d = cmd_i.key;
          pay_d = cmd_i.payload;
        end
      end
      CMD_DEL: begin
        if (MyIdx >= cmd_i.idx) begin
          key_d = next_key_i;
          pay_d = next_pay_i;
        end
      end
      CMD_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // Entry storage carries no reset; entries beyond the count are never used.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  // Signed compare against the broadcast search key.
  assign lt_o  = $signed(key_q) < want_i;
  assign eq_o  = $signed(key_q) == want_i;
  assign key_o = key_q;
  assign pay_o = pay_q;

  // Payload gated by index match, ORed together in the read tree.
  assign rd_o = (MyIdx == cmd_i.idx) ? pay_q : '0;

endmodule

// File: hdl/sorted_key_table.sv
// Sorted key table: a chain of cells holding keys in ascending order.
//
// Requests arrive on in_i (valid/ready) and each one yields exactly one
// transaction on out_o. A request is taken only when the sequencer is idle;
// the result sits in an output register, so the next request may be taken
// while the previous result still waits for out_o.ready.
// Every cell compares its key with the request key in parallel; a binary
// search then walks the registered compare flags, one probe per cycle.
// Insert and delete shift the cells from the target index onward by one place together, in S_EXEC.
// After acceptance, an out-of-range delete and the unused code go straight to
// S_FINISH; a delete passes through S_EXEC; a lookup passes through S_CMP and
// S_SEARCH, then on a hit through S_READ_GRP and S_READ_ALL; an insert passes
// through S_CMP, S_SEARCH and S_EXEC (a full table skips S_EXEC). S_FINISH
// loads the output register and returns to S_IDLE.
// Reset empties the table (count zero), drops the output valid and leaves the
// sequencer idle and ready; the entry storage is not cleared and needs no sweep.
// When the receiver stalls, the result is held and the block takes one more
// request, then holds in its final state until the output register frees up.
module sorted_key_table import sk_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sk_in_if.sink     in_i,
  sk_out_if.source  out_o
);

  localparam int IW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int NG   = (DEPTH + GrpSize - 1) / GrpSize;
  localparam int CmpW = (CW > PosW) ? CW : PosW;

  // Sequencer and request registers.
  fsm_e                   state_q, state_d;
  logic [FuncW-1:0]       func_q, func_d;
  logic signed [KeyW-1:0] key_q, key_d;
  logic [PayW-1:0]        pay_q, pay_d;
  logic [PosW-1:0]        pos_q, pos_d;
  logic [CW-1:0]          count_q, count_d;

  // Search state.
  logic [CW-1:0]          lo_q, lo_d;
  logic [CW-1:0]          hi_q, hi_d;
  logic [CW-1:0]          slot_q, slot_d;
  logic [DEPTH-1:0]       lt_q, eq_q;
  logic                   load_flags;

  // Result being assembled.
  logic                   hit_q, hit_d;
  logic [SlotW-1:0]       rslot_q, rslot_d;
  logic [PayW-1:0]        data_q, data_d;
  status_e                status_q, status_d;

  // Output register.
  logic                   ovalid_q, ovalid_d;
  logic                   oload;
  logic                   o_found_q;
  logic [SlotW-1:0]       o_slot_q;
  logic [PayW-1:0]        o_data_q;
  logic [CountW-1:0]      o_entries_q;
  logic [StatusW-1:0]     o_status_q;

  // Payload read tree.
  logic [PayW-1:0]        grp_d [NG];
  logic [PayW-1:0]        grp_q [NG];
  logic [PayW-1:0]        all_or;

  // Cell connections.
  shift_cmd_t             cmd;
  logic [KeyW-1:0]        cell_key [DEPTH];
  logic [PayW-1:0]        cell_pay [DEPTH];
  logic [KeyW-1:0]        prev_key [DEPTH];
  logic [PayW-1:0]        prev_pay [DEPTH];
  logic [KeyW-1:0]        next_key [DEPTH];
  logic [PayW-1:0]        next_pay [DEPTH];
  logic [PayW-1:0]        cell_rd  [DEPTH];
  logic [DEPTH-1:0]       cell_lt, cell_eq;

  // Probe position of the binary search.
  logic [CW:0]            mid_sum;
  logic [CW:0]            mid_wide;
  logic [IW-1:0]          mid;
  logic                   del_bad;
  logic                   full;

  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q} - {{CW{1'b0}}, 1'b1};
  assign mid_wide = mid_sum >> 1;
  assign mid      = mid_wide[IW-1:0];
  assign del_bad  = CmpW'(in_i.position) >= CmpW'(count_q);
  assign full     = count_q == CW'(DEPTH);

  // Row of cells.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_key[i] = '0;
      assign prev_pay[i] = '0;
    end else begin : g_mid
      assign prev_key[i] = cell_key[i-1];
      assign prev_pay[i] = cell_pay[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_key[i] = '0;
      assign next_pay[i] = '0;
    end else begin : g_inner
      assign next_key[i] = cell_key[i+1];
      assign next_pay[i] = cell_pay[i+1];
    end

    sk_cell #(.IDX(i)) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .want_i     (key_q),
      .prev_key_i (prev_key[i]),
      .prev_pay_i (prev_pay[i]),
      .next_key_i (next_key[i]),
      .next_pay_i (next_pay[i]),
      .key_o      (cell_key[i]),
      .pay_o      (cell_pay[i]),
      .lt_o       (cell_lt[i]),
      .eq_o       (cell_eq[i]),
      .rd_o       (cell_rd[i])
    );
  end

  // First level of the read tree: OR within each group of cells.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < GrpSize; j++) begin
        if (g * GrpSize + j < DEPTH) begin
          grp_d[g] = grp_d[g] | cell_rd[g * GrpSize + j];
        end
      end
    end
  end

  // Second level: OR across the registered groups.
  always_comb begin
    all_or = '0;
    for (int g = 0; g < NG; g++) begin
      all_or = all_or | grp_q[g];
    end
  end

  // Shift command broadcast to the cells.
  always_comb begin
    cmd.op      = CMD_NONE;
    cmd.idx     = (func_q == FN_DELETE) ? IdxMaxW'(pos_q) : IdxMaxW'(slot_q);
    cmd.key     = key_q;
    cmd.payload = pay_q;
    if (state_q == S_EXEC) begin
      cmd.op = (func_q == FN_INSERT) ? CMD_INS : CMD_DEL;
    end
  end

  // Next state and result assembly.
  always_comb begin
    state_d    = state_q;
    func_d     = func_q;
    key_d      = key_q;
    pay_d      = pay_q;
    pos_d      = pos_q;
    count_d    = count_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    slot_d     = slot_q;
    hit_d      = hit_q;
    rslot_d    = rslot_q;
    data_d     = data_q;
    status_d   = status_q;
    load_flags = 1'b0;
    oload      = 1'b0;
    in_i.ready = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          func_d   = in_i.func;
          key_d    = in_i.key;
          pay_d    = in_i.payload;
          pos_d    = in_i.position;
          hit_d    = 1'b0;
          data_d   = '0;
          status_d = STS_OK;
          rslot_d  = '0;
          unique case (in_i.func)
            FN_LOOKUP, FN_INSERT: begin
              state_d = S_CMP;
            end
            FN_DELETE: begin
              rslot_d = SlotW'(in_i.position);
              if (del_bad) begin
                status_d = STS_BADIDX;
                state_d  = S_FINISH;
              end else begin
                state_d = S_EXEC;
              end
            end
            default: begin
              state_d = S_FINISH;
            end
          endcase
        end
      end

      S_CMP: begin
        load_flags = 1'b1;
        lo_d       = '0;
        hi_d       = count_q;
        state_d    = S_SEARCH;
      end

      S_SEARCH: begin
        if (lo_q >= hi_q || eq_q[mid]) begin
          // Search ends: either a hit at the probe or the insertion point.
          if (lo_q >= hi_q) begin
            slot_d  = lo_q;
            hit_d   = 1'b0;
            rslot_d = SlotW'(lo_q);
          end else begin
            slot_d  = CW'(mid);
            hit_d   = 1'b1;
            rslot_d = SlotW'(mid);
          end
          if (func_q == FN_INSERT) begin
            if (full) begin
              status_d = STS_FULL;
              state_d  = S_FINISH;
            end else begin
              state_d = S_EXEC;
            end
          end else if (lo_q < hi_q) begin
            state_d = S_READ_GRP;
          end else begin
            state_d = S_FINISH;
          end
        end else if (lt_q[mid]) begin
          lo_d = mid_wide[CW-1:0] + CW'(1);
        end else begin
          hi_d = mid_wide[CW-1:0];
        end
      end

      S_READ_GRP: begin
        state_d = S_READ_ALL;
      end

      S_READ_ALL: begin
        data_d  = all_or;
        state_d = S_FINISH;
      end

      S_EXEC: begin
        if (func_q == FN_INSERT) begin
          count_d = count_q + CW'(1);
        end else begin
          count_d = count_q - CW'(1);
        end
        state_d = S_FINISH;
      end

      S_FINISH: begin
        if (!ovalid_q || out_o.ready) begin
          oload   = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid follows loads and completed transactions.
  always_comb begin
    ovalid_d = ovalid_q;
    if (oload) begin
      ovalid_d = 1'b1;
    end else if (out_o.ready) begin
      ovalid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    key_q    <= key_d;
    pay_q    <= pay_d;
    pos_q    <= pos_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    slot_q   <= slot_d;
    hit_q    <= hit_d;
    rslot_q  <= rslot_d;
    data_q   <= data_d;
    status_q <= status_d;
    if (load_flags) begin
      lt_q <= cell_lt;
      eq_q <= cell_eq;
    end
    if (state_q == S_READ_GRP) begin
      grp_q <= grp_d;
    end
    if (oload) begin
      o_found_q   <= hit_q;
      o_slot_q    <= rslot_q;
      o_data_q    <= data_q;
      o_entries_q <= CountW'(count_q);
      o_status_q  <= status_q;
    end
  end

  assign out_o.valid   = ovalid_q;
  assign out_o.found   = o_found_q;
  assign out_o.slot    = o_slot_q;
  assign out_o.data    = o_data_q;
  assign out_o.entries = o_entries_q;
  assign out_o.status  = o_status_q;

  // The entry count never passes the table size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above table size");

  // The search window never inverts while probing.
  a_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH |-> lo_q <= hi_q)
    else $error("search window inverted");

  // An executed insert grows the table by exactly one entry.
  a_insert_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && func_q == FN_INSERT) |=>
      count_q == CW'($past(count_q) + CW'(1)))
    else $error("insert did not grow the count by one");

endmodule
